[sv/vas_pkg.sv]
`default_nettype none
package vas_pkg;

    localparam int SAMPLE_W = 16;
    localparam int MAG_W    = 16;
    localparam int WINLEN_W = 10;
    localparam int LIMIT_W  = 15;
    localparam int OUTSUM_W = 25;
    localparam int APB_AW   = 3;
    localparam int APB_DW   = 32;

    localparam logic [WINLEN_W-1:0] WINLEN_RESET = 10'd400;
    localparam logic [LIMIT_W-1:0]  LIMIT_RESET  = 15'd0;

    // register index = paddr[2]
    typedef enum logic {
        REG_WINDOW_LEN  = 1'b0,
        REG_LEVEL_LIMIT = 1'b1
    } t_reg_idx;

    typedef struct packed {
        logic [WINLEN_W-1:0] window_len;
        logic [LIMIT_W-1:0]  level_limit;
    } t_cfg;

endpackage
`default_nettype wire

[sv/voice_activity_squelch.sv]
`default_nettype none
// Flow: an accepted beat passes the stage 1 register, then the output register.
// Throughput: one beat per cycle while the output is not stalled, set by the single
// ring RAM read at accept and the stage 1 write-back (same-slot overlap is forwarded).
// Reset (synchronous, active low): sum, write position, fill mark and valid flags clear
// at once; the ring is not swept - a fill mark treats slots never written as zero.
module voice_activity_squelch #(
    parameter int MAX_WINDOW = 512
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    // sample stream in
    input  wire                          i_s_tvalid,
    output logic                         o_s_tready,
    input  wire [15:0]                   i_s_tdata,  // [15:0] sample
    // result stream out
    output logic                         o_m_tvalid,
    input  wire                          i_m_tready,
    output logic [31:0]                  o_m_tdata,  // [24:0] window_sum, [31:25] zero
    output logic [0:0]                   o_m_tuser,  // [0] open
    // config
    input  wire                          i_psel,
    input  wire                          i_penable,
    input  wire                          i_pwrite,
    input  wire [vas_pkg::APB_AW-1:0]    i_paddr,
    input  wire [vas_pkg::APB_DW-1:0]    i_pwdata,
    output logic [vas_pkg::APB_DW-1:0]   o_prdata,
    output logic                         o_pready
);
    import vas_pkg::*;

    localparam int POS_W = $clog2(MAX_WINDOW);
    localparam int LEN_W = $clog2(MAX_WINDOW + 1);
    localparam int EXT_W = (LEN_W > WINLEN_W) ? LEN_W : WINLEN_W;
    localparam int SUM_W = POS_W + MAG_W;          // holds MAX_WINDOW * 32768
    localparam int THR_W = LIMIT_W + LEN_W;
    localparam int CMP_W = (THR_W > SUM_W) ? THR_W : SUM_W;

    t_cfg cfg;

    vas_regs u_regs (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_psel    (i_psel),
        .i_penable (i_penable),
        .i_pwrite  (i_pwrite),
        .i_paddr   (i_paddr),
        .i_pwdata  (i_pwdata),
        .o_prdata  (o_prdata),
        .o_pready  (o_pready),
        .o_cfg     (cfg)
    );

    // effective window length: 0 -> 1, clamp at MAX_WINDOW
    logic [EXT_W-1:0] wl_ext;
    logic [LEN_W-1:0] eff_len;

    assign wl_ext = EXT_W'(cfg.window_len);

    always_comb begin
        if (wl_ext == '0) begin
            eff_len = LEN_W'(1);
        end else if (wl_ext > EXT_W'(MAX_WINDOW)) begin
            eff_len = LEN_W'(MAX_WINDOW);
        end else begin
            eff_len = LEN_W'(wl_ext);
        end
    end

    // threshold depends on config only; config must be stable while items flow (not enforced here)
    logic [THR_W-1:0] r_thr;

    always_ff @(posedge i_clk) begin
        r_thr <= THR_W'(cfg.level_limit) * THR_W'(eff_len);
    end

    // ---- accept stage: magnitude, ring read, position advance ----
    logic             s_acc;
    logic             s1_go;
    logic [MAG_W-1:0] mag;
    logic [POS_W-1:0] r_pos;
    logic [LEN_W-1:0] r_fill;      // slots [0, r_fill) have been written since reset
    logic [LEN_W-1:0] pos_ext;

    // two's complement negate; -32768 maps to 32768 in 16 unsigned bits
    assign mag     = i_s_tdata[SAMPLE_W-1] ? (~i_s_tdata + MAG_W'(1)) : i_s_tdata;
    assign pos_ext = LEN_W'(r_pos);

    // stage 1 / output register
    logic             r_s1_v;
    logic [POS_W-1:0] r_s1_pos;
    logic [MAG_W-1:0] r_s1_mag;
    logic             r_s1_fwd;    // slot is being written by the previous beat
    logic [MAG_W-1:0] r_s1_fwd_data;
    logic             r_s1_hit;    // slot was written before: take RAM data
    logic             r_o_v;

    assign s1_go      = r_s1_v & (~r_o_v | i_m_tready);
    assign o_s_tready = ~r_s1_v | s1_go;
    assign s_acc      = i_s_tvalid & o_s_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos  <= '0;
            r_fill <= '0;
            r_s1_v <= 1'b0;
        end else begin
            if (s_acc) begin
                r_pos <= (pos_ext >= eff_len - LEN_W'(1)) ? '0 : r_pos + POS_W'(1);
                // position never passes the fill mark, so hitting it extends it
                if (pos_ext == r_fill) begin
                    r_fill <= r_fill + LEN_W'(1);
                end
                r_s1_v <= 1'b1;
            end else if (s1_go) begin
                r_s1_v <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_acc) begin
            r_s1_pos      <= r_pos;
            r_s1_mag      <= mag;
            r_s1_fwd      <= s1_go & (r_s1_pos == r_pos);
            r_s1_fwd_data <= r_s1_mag;
            r_s1_hit      <= pos_ext < r_fill;
        end
    end

    // ---- ring memory ----
    logic [MAG_W-1:0] ram_q;

    vas_ram #(
        .WIDTH (MAG_W),
        .DEPTH (MAX_WINDOW)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (s1_go),
        .i_waddr (r_s1_pos),
        .i_wdata (r_s1_mag),
        .i_re    (s_acc),
        .i_raddr (r_pos),
        .o_rdata (ram_q)
    );

    // ---- commit stage: sum update, compare, write-back ----
    logic [MAG_W-1:0]          old_mag;
    logic [SUM_W-1:0]          r_sum;
    logic [SUM_W-1:0]          n_sum;
    logic [SUM_W+OUTSUM_W-1:0] sum_wide;
    logic                      n_open;
    logic [OUTSUM_W-1:0]       r_o_sum;
    logic                      r_o_open;

    always_comb begin
        if (r_s1_fwd) begin
            old_mag = r_s1_fwd_data;
        end else if (r_s1_hit) begin
            old_mag = ram_q;
        end else begin
            old_mag = '0;
        end
    end

    assign n_sum    = r_sum - SUM_W'(old_mag) + SUM_W'(r_s1_mag);
    assign n_open   = CMP_W'(n_sum) >= CMP_W'(r_thr);
    assign sum_wide = {{OUTSUM_W{1'b0}}, n_sum};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum <= '0;
            r_o_v <= 1'b0;
        end else begin
            if (s1_go) begin
                r_sum <= n_sum;
                r_o_v <= 1'b1;
            end else if (i_m_tready) begin
                r_o_v <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_go) begin
            r_o_sum  <= sum_wide[OUTSUM_W-1:0];
            r_o_open <= n_open;
        end
    end

    assign o_m_tvalid = r_o_v;
    assign o_m_tdata  = {{(32-OUTSUM_W){1'b0}}, r_o_sum};
    assign o_m_tuser  = r_o_open;

endmodule
`default_nettype wire

[sv/vas_ram.sv]
`default_nettype none
module vas_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 512
) (
    input  wire                       i_clk,
    input  wire                       i_we,
    input  wire [$clog2(DEPTH)-1:0]   i_waddr,
    input  wire [WIDTH-1:0]           i_wdata,
    input  wire                       i_re,
    input  wire [$clog2(DEPTH)-1:0]   i_raddr,
    output logic [WIDTH-1:0]          o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule
`default_nettype wire

[sv/vas_regs.sv]
`default_nettype none
module vas_regs (
    input  wire                        i_clk,
    input  wire                        i_rst_n,
    input  wire                        i_psel,
    input  wire                        i_penable,
    input  wire                        i_pwrite,
    input  wire [vas_pkg::APB_AW-1:0]  i_paddr,
    input  wire [vas_pkg::APB_DW-1:0]  i_pwdata,
    output logic [vas_pkg::APB_DW-1:0] o_prdata,
    output logic                       o_pready,
    output vas_pkg::t_cfg              o_cfg
);
    import vas_pkg::*;

    t_cfg     r_cfg;
    t_reg_idx reg_idx;
    logic     wr_en;

    assign reg_idx  = t_reg_idx'(i_paddr[2]);
    assign o_pready = 1'b1;
    assign wr_en    = i_psel & i_penable & i_pwrite & o_pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.window_len  <= WINLEN_RESET;
            r_cfg.level_limit <= LIMIT_RESET;
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_WINDOW_LEN:  r_cfg.window_len  <= i_pwdata[WINLEN_W-1:0];
                REG_LEVEL_LIMIT: r_cfg.level_limit <= i_pwdata[LIMIT_W-1:0];
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_WINDOW_LEN:  o_prdata = {{(APB_DW-WINLEN_W){1'b0}}, r_cfg.window_len};
            REG_LEVEL_LIMIT: o_prdata = {{(APB_DW-LIMIT_W){1'b0}}, r_cfg.level_limit};
        endcase
    end

    assign o_cfg = r_cfg;

endmodule
`default_nettype wire

[sim/squelch_checker.sv]
`timescale 1ns / 1ps
// Watches the sample and result streams and the register port, keeps its own
// copy of the squelch state and checks every result beat in order.
module squelch_checker (
    input  wire                         i_clk,
    input  wire                         i_rst_n,
    input  wire                         i_s_tvalid,
    input  wire                         i_s_tready,
    input  wire [15:0]                  i_s_tdata,   // [15:0] sample
    input  wire                         i_m_tvalid,
    input  wire                         i_m_tready,
    input  wire [31:0]                  i_m_tdata,   // [24:0] window_sum, [31:25] zero
    input  wire [0:0]                   i_m_tuser,   // [0] open
    input  wire                         i_psel,
    input  wire                         i_penable,
    input  wire                         i_pwrite,
    input  wire                         i_pready,
    input  wire [vas_pkg::APB_AW-1:0]   i_paddr,
    input  wire [vas_pkg::APB_DW-1:0]   i_pwdata,
    output int                          o_fail_count,
    output int                          o_pending
);
    import vas_pkg::*;

    localparam int RING_DEPTH = 512;
    localparam int REPORT_MAX = 10;

    typedef struct packed {
        logic                open;
        logic [OUTSUM_W-1:0] window_sum;
    } t_level;

    t_cfg             cfg;
    logic [MAG_W-1:0] mag_ring [RING_DEPTH];
    int unsigned      wr_pos;
    int unsigned      level_sum;
    logic             squelch_open;
    t_level           level_q [$];

    // zero acts as one, anything past the ring depth saturates
    function automatic int unsigned active_len(input logic [WINLEN_W-1:0] n);
        if (n == '0)
            return 1;
        if (n > RING_DEPTH)
            return RING_DEPTH;
        return n;
    endfunction

    // advances the squelch state by one sample, returns the level it reports
    function automatic t_level track_level(input logic [SAMPLE_W-1:0] raw);
        int unsigned     len;
        int unsigned     pos;
        logic [MAG_W:0]  mag;
        longint unsigned open_level;
        t_level          res;
        len = active_len(cfg.window_len);
        pos = (wr_pos >= RING_DEPTH) ? 0 : wr_pos;
        // -32768 keeps its full magnitude
        mag = raw[SAMPLE_W-1] ? (17'h10000 - {1'b0, raw}) : {1'b0, raw};
        level_sum = level_sum - mag_ring[pos] + mag;
        mag_ring[pos] = mag[MAG_W-1:0];
        wr_pos = (pos >= len - 1) ? 0 : pos + 1;
        open_level = 64'(cfg.level_limit) * 64'(len);
        squelch_open = (64'(level_sum) >= open_level);
        res.open = squelch_open;
        res.window_sum = level_sum[OUTSUM_W-1:0];
        return res;
    endfunction

    task automatic note_failure(input string what, input t_level want, input t_level got);
        o_fail_count++;
        if (o_fail_count <= REPORT_MAX)
            $display("%0t: %s: expected open=%0d sum=%0d, got open=%0d sum=%0d",
                     $realtime, what, want.open, want.window_sum, got.open, got.window_sum);
    endtask

    always @(posedge i_clk) begin
        t_level got;
        t_level want;
        if (!i_rst_n) begin
            cfg.window_len  = WINLEN_RESET;
            cfg.level_limit = LIMIT_RESET;
            foreach (mag_ring[k])
                mag_ring[k] = '0;
            wr_pos       = 0;
            level_sum    = 0;
            squelch_open = 1'b0;
            o_fail_count = 0;
            level_q.delete();
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                case (t_reg_idx'(i_paddr[2]))
                    REG_WINDOW_LEN:  cfg.window_len  = i_pwdata[WINLEN_W-1:0];
                    REG_LEVEL_LIMIT: cfg.level_limit = i_pwdata[LIMIT_W-1:0];
                    default: ;
                endcase
            end
            // result side first so a beat never matches the sample of the same edge
            if (i_m_tvalid && i_m_tready) begin
                got.open       = i_m_tuser[0];
                got.window_sum = i_m_tdata[OUTSUM_W-1:0];
                if (level_q.size() == 0) begin
                    want = '0;
                    note_failure("result beat with nothing pending", want, got);
                end else begin
                    want = level_q.pop_front();
                    if (got.open !== want.open || got.window_sum !== want.window_sum)
                        note_failure("result mismatch", want, got);
                end
            end
            if (i_s_tvalid && i_s_tready)
                level_q.push_back(track_level(i_s_tdata));
        end
        o_pending = level_q.size();
    end

endmodule

[sim/testbench.sv]
`timescale 1ns / 1ps
// Stimulus and verdict for the squelch. The checker beside the block does all
// prediction; this module only drives beats, receiver ready and register writes.
module testbench;
    import vas_pkg::*;

    localparam int HOLD_CYCLES = 300;   // one long result-side stall
    localparam int NUM_PHASES  = 10;    // random phases, ~200 beats each

    logic                clk;
    logic                rst_n;
    logic                s_tvalid;
    logic                s_tready;
    logic [15:0]         s_tdata;       // [15:0] sample
    logic                m_tvalid;
    logic                m_tready;
    logic [31:0]         m_tdata;       // [24:0] window_sum, [31:25] zero
    logic [0:0]          m_tuser;       // [0] open
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [APB_AW-1:0]   paddr;
    logic [APB_DW-1:0]   pwdata;
    logic [APB_DW-1:0]   prdata;
    logic                pready;

    int   fail_count;
    int   pending;
    logic no_gaps  = 1'b0;   // sender streams back to back while set
    logic hold_req = 1'b0;   // asks the receiver for one long stall

    voice_activity_squelch dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata),
        .o_m_tuser  (m_tuser),
        .i_psel     (psel),
        .i_penable  (penable),
        .i_pwrite   (pwrite),
        .i_paddr    (paddr),
        .i_pwdata   (pwdata),
        .o_prdata   (prdata),
        .o_pready   (pready)
    );

    squelch_checker u_check (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_s_tvalid   (s_tvalid),
        .i_s_tready   (s_tready),
        .i_s_tdata    (s_tdata),
        .i_m_tvalid   (m_tvalid),
        .i_m_tready   (m_tready),
        .i_m_tdata    (m_tdata),
        .i_m_tuser    (m_tuser),
        .i_psel       (psel),
        .i_penable    (penable),
        .i_pwrite     (pwrite),
        .i_pready     (pready),
        .i_paddr      (paddr),
        .i_pwdata     (pwdata),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // hard stop; the slowest legal run is far shorter
    initial begin
        #20_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    // idle length: mostly none or short, now and then long
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 98)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [WINLEN_W-1:0] pick_window();
        case ($urandom_range(0, 9))
            0:       return '0;                          // acts as 1
            1:       return 10'd1;
            2:       return 10'd2;
            3:       return 10'd512;
            4:       return 10'd1023;                    // saturates
            5:       return 10'($urandom_range(513, 1022));
            6, 7:    return 10'($urandom_range(3, 32));
            default: return 10'($urandom_range(33, 511));
        endcase
    endfunction

    // limits mostly near typical levels so the squelch actually toggles
    function automatic logic [LIMIT_W-1:0] pick_limit();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return 15'd32767;
            2:       return 15'($urandom_range(0, 32767));
            default: return 15'($urandom_range(500, 16000));
        endcase
    endfunction

    // one sample beat; returns on the accepting edge plus any idle after it
    task automatic push_sample(input logic [15:0] sample);
        int gap;
        s_tvalid <= 1'b1;
        s_tdata  <= sample;
        do @(posedge clk); while (!s_tready);
        gap = no_gaps ? 0 : idle_len();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // stop sending and wait until every result is back; ends on a rising edge.
    // pending is read on the falling edge so the checker has settled.
    task automatic drain();
        s_tvalid <= 1'b0;
        do @(negedge clk); while (pending != 0);
        repeat (2) @(posedge clk);   // covers the output stage
    endtask

    // setup + access, then idle so back-to-back writes never collide
    task automatic reg_write(input t_reg_idx idx, input logic [APB_DW-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    // receiver: random ready runs and stalls, plus the one long hold-off,
    // which cuts the current run short so it lands while the sender streams
    initial begin
        int run;
        int gap;
        m_tready = 1'b0;
        @(posedge clk);
        forever begin
            if (hold_req) begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_req = 1'b0;
            end else begin
                run = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
                                                  : $urandom_range(1, 20);
                m_tready <= 1'b1;
                for (int i = 0; i < run && !hold_req; i++)
                    @(posedge clk);
                gap = hold_req ? 0 : idle_len();
                if (gap > 0) begin
                    m_tready <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
            end
        end
    end

    // sender and register writes
    initial begin
        logic [15:0] edge_samples [9];
        int          n_beats;
        int          burst_left;
        int          burst_amp;
        int          mag;
        logic [15:0] sample;

        s_tvalid = 1'b0;
        s_tdata  = '0;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;
        rst_n    = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // --- directed ---
        // reset settings (window 400, limit 0: always open); field extremes,
        // including the most negative sample and alternating bit patterns
        edge_samples = '{16'h0000, 16'h7FFF, 16'h8000, 16'hFFFF, 16'h0001,
                         16'h8001, 16'h5555, 16'hAAAA, 16'h7FFF};
        foreach (edge_samples[k])
            push_sample(edge_samples[k]);

        // zero window acts as one; write position lies past it and wraps.
        // stale ring entries stay in the sum.
        drain();
        reg_write(REG_WINDOW_LEN, 32'd0);
        reg_write(REG_LEVEL_LIMIT, 32'd32767);
        push_sample(16'h8000);
        push_sample(16'h7FFF);
        push_sample(16'h7FFE);
        push_sample(16'h0000);

        // oversize window saturates at the ring depth
        drain();
        reg_write(REG_WINDOW_LEN, 32'd1023);
        push_sample(16'h8000);
        push_sample(16'h8000);
        push_sample(16'h8000);

        // tiny window with the top limit: open only on full-scale beats
        drain();
        reg_write(REG_WINDOW_LEN, 32'd2);
        push_sample(16'h8000);
        push_sample(16'h8000);
        push_sample(16'h7FFF);
        push_sample(16'h0000);

        // --- random phases ---
        // speech-like bursts of random loudness, some raw noise beats
        burst_left = 0;
        burst_amp  = 0;
        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            drain();
            case (ph)
                0: begin
                    reg_write(REG_WINDOW_LEN, 32'd512);
                    reg_write(REG_LEVEL_LIMIT, 32'(pick_limit()));
                end
                1: begin
                    reg_write(REG_WINDOW_LEN, 32'd1023);
                    reg_write(REG_LEVEL_LIMIT, 32'd32767);
                end
                default: begin
                    reg_write(REG_WINDOW_LEN, 32'(pick_window()));
                    reg_write(REG_LEVEL_LIMIT, 32'(pick_limit()));
                end
            endcase
            no_gaps = ($urandom_range(0, 4) == 0);
            if (ph == 2) begin
                // receiver stalls while the sender keeps pushing: block backs up
                no_gaps  = 1'b1;
                hold_req = 1'b1;
            end
            n_beats = $urandom_range(170, 230);
            for (int b = 0; b < n_beats; b++) begin
                if (burst_left == 0) begin
                    burst_left = $urandom_range(1, 80);
                    case ($urandom_range(0, 4))
                        0:       burst_amp = 0;
                        1:       burst_amp = $urandom_range(1, 300);
                        2:       burst_amp = $urandom_range(301, 12000);
                        default: burst_amp = $urandom_range(12001, 32768);
                    endcase
                end
                burst_left--;
                if ($urandom_range(0, 19) == 0) begin
                    sample = 16'($urandom());
                end else begin
                    mag    = $urandom_range(0, burst_amp);
                    sample = $urandom_range(0, 1) ? 16'(-mag) : 16'(mag);
                end
                push_sample(sample);
                // occasional pause until every result is home
                if ($urandom_range(0, 299) == 0)
                    drain();
            end
        end

        drain();
        if (fail_count == 0 && pending == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

[sim.f]
sv/vas_pkg.sv
sv/vas_ram.sv
sv/vas_regs.sv
sv/voice_activity_squelch.sv
sim/squelch_checker.sv
sim/testbench.sv
